/* hw/rtl/llq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_pkg
// Shared types and constants of the linked list queue manager: request
// opcodes, field widths, controller states and the command bundle.
// ----------------------------------------------------------------------------
package llq_pkg;

  // fixed field widths of the request and response items
  localparam int OPCODE_W = 3;
  localparam int IDX_W    = 8;
  localparam int LEN_W    = 9;

  // default size of the node pool
  localparam int DEF_NUM_NODES = 256;

  // request opcodes, codes five to seven do nothing
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_UNLINK    = 3'd2,
    OP_SHIFT     = 3'd3,
    OP_PEEK      = 3'd4
  } llq_op_t;

  // response status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } llq_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;   // item taken: decode, first link writes, link reads
    logic commit;  // second link writes, head/tail/count update, load output
  } llq_cmd_t;

endpackage : llq_pkg
`default_nettype wire

/* hw/rtl/llq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_if
// Valid/ready channels of the queue manager: request and response items.
// ----------------------------------------------------------------------------
interface llq_req_if import llq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [IDX_W-1:0]    node_index;

  modport source (output valid, output opcode, output node_index, input ready);
  modport sink   (input valid, input opcode, input node_index, output ready);
endinterface : llq_req_if

interface llq_rsp_if import llq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] head_node;
  logic             found;
  logic [LEN_W-1:0] length;
  logic             status;

  modport source (output valid, output head_node, output found, output length,
                  output status, input ready);
  modport sink   (input valid, input head_node, input found, input length,
                  input status, output ready);
endinterface : llq_rsp_if
`default_nettype wire

/* hw/rtl/llq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_ctrl
// Controller: takes one item, runs its commit step once the output register
// is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
module llq_ctrl import llq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output llq_cmd_t      cmd
);

  llq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // output register can take a new item this cycle
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_COMMIT: begin
        cmd.commit = slot_free;
      end
      default: ;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a taken item always reaches its commit step next
  a_start_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == ST_COMMIT)
    else $error("taken item did not move to commit");

  // a response only appears after a commit
  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("response valid without commit");

  // a pending response is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.commit)
    else $error("commit while response stalled");

endmodule : llq_ctrl
`default_nettype wire

/* hw/rtl/llq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_dp
// Datapath: next and prev link memories, head/tail/count registers, the
// decoded item and the output register.
// ----------------------------------------------------------------------------
module llq_dp import llq_pkg::*; #(
  parameter int NUM_NODES = DEF_NUM_NODES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire llq_cmd_t            cmd,
  input  wire logic [OPCODE_W-1:0] in_opcode,
  input  wire logic [IDX_W-1:0]    in_node_index,
  output logic [IDX_W-1:0]         out_head_node,
  output logic                     out_found,
  output logic [LEN_W-1:0]         out_length,
  output logic                     out_status
);

  localparam int IW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int LW = $clog2(NUM_NODES + 1);
  localparam logic [LW-1:0] NONE = LW'(NUM_NODES);

  typedef logic [LW-1:0] link_t;

  // link memories, contents undefined until written
  link_t next_mem [NUM_NODES];
  link_t prev_mem [NUM_NODES];

  link_t first_r, first_nxt;
  link_t last_r, last_nxt;
  link_t count_r, count_nxt;

  // decoded item
  link_t            node_r;
  logic             ph_r, pt_r, rm_r, err_r, found_r;
  logic [IDX_W-1:0] head_r;

  // registered link reads
  link_t next_rd_r, prev_rd_r;

  // decode of the incoming item
  logic             s_ph, s_pt, s_rm, s_err, s_found;
  logic [IDX_W-1:0] s_head;
  logic             idx_ok;
  link_t            n_link, rd_link;

  // memory write ports
  logic          next_we, prev_we;
  logic [IW-1:0] next_waddr, prev_waddr;
  link_t         next_wdata, prev_wdata;

  function automatic logic is_node(link_t l);
    return l < NONE;
  endfunction

  assign idx_ok = 32'(in_node_index) < NUM_NODES;
  assign n_link = LW'(in_node_index);

  // request decode
  always_comb begin
    s_ph    = 1'b0;
    s_pt    = 1'b0;
    s_rm    = 1'b0;
    s_err   = 1'b0;
    s_found = 1'b0;
    s_head  = '0;
    rd_link = n_link;
    unique case (in_opcode) inside
      OP_PUSH_HEAD: s_ph = idx_ok;
      OP_PUSH_TAIL: s_pt = idx_ok;
      OP_UNLINK: begin
        if (idx_ok) begin
          s_err = count_r == '0;
          s_rm  = count_r != '0;
        end
      end
      OP_SHIFT, OP_PEEK: begin
        if (is_node(first_r)) begin
          s_found = 1'b1;
          s_head  = IDX_W'(first_r);
          rd_link = first_r;
          if (in_opcode == OP_SHIFT) begin
            s_err = count_r == '0;
            s_rm  = count_r != '0;
          end
        end
      end
      default: ;
    endcase
  end

  // link writes and head/tail/count update
  always_comb begin
    next_we    = 1'b0;
    next_waddr = n_link[IW-1:0];
    next_wdata = NONE;
    prev_we    = 1'b0;
    prev_waddr = n_link[IW-1:0];
    prev_wdata = NONE;
    first_nxt  = first_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    if (cmd.start) begin
      // new node gets its own links first
      if (s_ph) begin
        next_we    = 1'b1;
        next_wdata = first_r;
        prev_we    = 1'b1;
        prev_wdata = NONE;
      end else if (s_pt) begin
        next_we    = 1'b1;
        next_wdata = NONE;
        prev_we    = 1'b1;
        prev_wdata = last_r;
      end
    end else if (cmd.commit) begin
      if (ph_r) begin
        // old head points back to the new node
        if (is_node(first_r)) begin
          prev_we    = 1'b1;
          prev_waddr = first_r[IW-1:0];
          prev_wdata = node_r;
        end else begin
          last_nxt = node_r;
        end
        first_nxt = node_r;
        if (count_r < NONE) count_nxt = count_r + 1'b1;
      end else if (pt_r) begin
        // old tail points on to the new node
        if (is_node(last_r)) begin
          next_we    = 1'b1;
          next_waddr = last_r[IW-1:0];
          next_wdata = node_r;
        end else begin
          first_nxt = node_r;
        end
        last_nxt = node_r;
        if (count_r < NONE) count_nxt = count_r + 1'b1;
      end else if (rm_r) begin
        // neighbors of the removed node are joined
        if (is_node(prev_rd_r)) begin
          next_we    = 1'b1;
          next_waddr = prev_rd_r[IW-1:0];
          next_wdata = next_rd_r;
        end else begin
          first_nxt = next_rd_r;
        end
        if (is_node(next_rd_r)) begin
          prev_we    = 1'b1;
          prev_waddr = next_rd_r[IW-1:0];
          prev_wdata = prev_rd_r;
        end else begin
          last_nxt = prev_rd_r;
        end
        count_nxt = count_r - 1'b1;
      end
    end
  end

  // link memories
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (cmd.start && s_rm) begin
      next_rd_r <= next_mem[rd_link[IW-1:0]];
      prev_rd_r <= prev_mem[rd_link[IW-1:0]];
    end
  end

  // head, tail, count and decoded item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= NONE;
      last_r  <= NONE;
      count_r <= '0;
      ph_r    <= 1'b0;
      pt_r    <= 1'b0;
      rm_r    <= 1'b0;
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
      if (cmd.start) begin
        ph_r <= s_ph;
        pt_r <= s_pt;
        rm_r <= s_rm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      node_r  <= rd_link;
      err_r   <= s_err;
      found_r <= s_found;
      head_r  <= s_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_head_node <= head_r;
      out_found     <= found_r;
      out_length    <= LEN_W'(count_nxt);
      out_status    <= err_r ? STATUS_EMPTY : STATUS_OK;
    end
  end

  // count never passes the pool size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NONE)
    else $error("node count above pool size");

  // a removal lowers the count by one
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && rm_r && !ph_r && !pt_r) |=> count_r == LW'($past(count_r) - 1'b1))
    else $error("removal did not decrement count");

  // a push at the head makes the node the new head
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && ph_r) |=> first_r == $past(node_r))
    else $error("head push did not set head");

endmodule : llq_dp
`default_nettype wire

/* hw/rtl/linked_list_queue_manager.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linked_list_queue_manager
// Doubly linked queue over a fixed pool of node indices.
// ----------------------------------------------------------------------------
// Each request item pushes a node at the head or tail, unlinks a member node,
// shifts the head off or peeks at it (unused codes do nothing), and yields
// exactly one response item with the head node (peek/shift), a found flag, the
// length after the request and a status bit set when a removal meets a zero
// count. An item runs in two steps: the cycle it is taken writes the new
// node's own links or reads the links of the node being removed, and the
// commit step writes the neighbor links, updates head, tail and count, and
// loads the output register. The two steps come from the single write port of
// each link memory and its registered read. A new item is taken as soon as the
// previous one has been committed, even while its response still waits; the
// commit step waits only while the output register is full. Link memories need
// no clearing after reset. Pushing a node that is already queued or unlinking
// a non-member is not checked and corrupts the order.
// ----------------------------------------------------------------------------
module linked_list_queue_manager import llq_pkg::*; #(
  parameter int NUM_NODES = DEF_NUM_NODES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  llq_req_if.sink   in_chan,
  llq_rsp_if.source out_chan
);

  llq_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;

  // sequencing and handshakes
  llq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // links, head/tail/count and output register
  llq_dp #(
    .NUM_NODES (NUM_NODES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_opcode     (in_chan.opcode),
    .in_node_index (in_chan.node_index),
    .out_head_node (out_chan.head_node),
    .out_found     (out_chan.found),
    .out_length    (out_chan.length),
    .out_status    (out_chan.status)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule : linked_list_queue_manager
`default_nettype wire

/* tb/sv/linked_list_queue_manager_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_queue_manager_tb
// Self-checking bench for the doubly linked queue manager. A shadow copy of
// the head, tail, count and link arrays predicts every response item. A short
// table of directed requests covers the empty queue, unused opcodes, extreme
// node indices and a removal that leaves a head behind a zero count. Random
// well-formed traffic follows under three idle/stall mixes, and the run ends
// by filling the pool past saturation with the response side first held off.
// ----------------------------------------------------------------------------
module linked_list_queue_manager_tb;
  import llq_pkg::*;

  localparam int NODES = DEF_NUM_NODES;
  localparam logic [LEN_W-1:0] NIL = LEN_W'(NODES);

  // opcodes with no function
  localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RAND_ITEMS  = 750;
  localparam int GOAL_PERIOD = 48;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 100;
  localparam int DIR_ROWS    = 26;

  typedef struct packed {
    logic [IDX_W-1:0] head_node;
    logic             found;
    logic [LEN_W-1:0] length;
    logic             status;
  } rsp_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [IDX_W-1:0]    idx;
    logic                fixed;
    logic [IDX_W-1:0]    w_head;
    logic                w_found;
    logic [LEN_W-1:0]    w_len;
    logic                w_status;
  } dir_row_t;

  // directed requests; fixed rows carry their response, the rest are predicted
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{OP_PEEK,      8'd0,   1'b1, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_SHIFT,     8'd0,   1'b1, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_UNLINK,    8'd255, 1'b1, 8'd0,   1'b0, 9'd0, STATUS_EMPTY},
    '{OP_SPARE_7,   8'd255, 1'b1, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_SPARE_5,   8'd0,   1'b1, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_PUSH_HEAD, 8'd255, 1'b1, 8'd0,   1'b0, 9'd1, STATUS_OK},
    '{OP_PEEK,      8'd0,   1'b1, 8'd255, 1'b1, 9'd1, STATUS_OK},
    '{OP_PUSH_TAIL, 8'd0,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_PUSH_HEAD, 8'd128, 1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_PUSH_HEAD, 8'd170, 1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_UNLINK,    8'd255, 1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_UNLINK,    8'd170, 1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_SHIFT,     8'd0,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_SHIFT,     8'd0,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_SHIFT,     8'd0,   1'b1, 8'd0,   1'b0, 9'd0, STATUS_OK},
    // node 77 ends up unlinked with both links at the anchor
    '{OP_PUSH_TAIL, 8'd77,  1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_UNLINK,    8'd77,  1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    // second unlink of node 1 leaves node 2 at the head with a zero count
    '{OP_PUSH_TAIL, 8'd1,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_PUSH_TAIL, 8'd2,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_UNLINK,    8'd1,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_UNLINK,    8'd1,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_SHIFT,     8'd0,   1'b1, 8'd2,   1'b1, 9'd0, STATUS_EMPTY},
    '{OP_PEEK,      8'd0,   1'b1, 8'd2,   1'b1, 9'd0, STATUS_OK},
    // stale links of node 77 clear head and tail again
    '{OP_PUSH_TAIL, 8'd3,   1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_UNLINK,    8'd77,  1'b0, 8'd0,   1'b0, 9'd0, STATUS_OK},
    '{OP_PEEK,      8'd0,   1'b1, 8'd0,   1'b0, 9'd0, STATUS_OK}
  };

  logic clk;
  logic rst_n;

  llq_req_if in_if ();
  llq_rsp_if out_if ();

  linked_list_queue_manager #(
    .NUM_NODES(NODES)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // shadow queue state
  logic [LEN_W-1:0] next_lnk [NODES];
  logic [LEN_W-1:0] prev_lnk [NODES];
  logic [LEN_W-1:0] head_ptr;
  logic [LEN_W-1:0] tail_ptr;
  logic [LEN_W-1:0] q_len;
  bit               on_list [NODES];

  rsp_t pending_rsp [$];
  rsp_t rsp_got;
  rsp_t rsp_want;
  int   err_cnt;
  int   quiet_cycles;
  int   src_idle_pct;
  int   snk_stall_pct;
  int   fill_goal;
  bit   hold_rsp;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // link writes; the none marker stands for the head/tail anchor
  function automatic void put_next(input logic [LEN_W-1:0] pos, input logic [LEN_W-1:0] val);
    if (pos < NIL) begin
      next_lnk[pos[IDX_W-1:0]] = val;
    end else begin
      head_ptr = val;
    end
  endfunction

  function automatic void put_prev(input logic [LEN_W-1:0] pos, input logic [LEN_W-1:0] val);
    if (pos < NIL) begin
      prev_lnk[pos[IDX_W-1:0]] = val;
    end else begin
      tail_ptr = val;
    end
  endfunction

  // insert node between two positions, count saturates at the pool size
  function automatic void link_in(input logic [LEN_W-1:0] node, input logic [LEN_W-1:0] bef,
                                  input logic [LEN_W-1:0] aft);
    put_next(node, aft);
    put_prev(node, bef);
    put_prev(aft, node);
    put_next(bef, node);
    if (q_len < NIL) q_len = q_len + 1'b1;
  endfunction

  // remove node using its own links; refused on a zero count
  function automatic logic unlink_node(input logic [IDX_W-1:0] node);
    logic [LEN_W-1:0] bef;
    logic [LEN_W-1:0] aft;
    if (q_len == '0) return STATUS_EMPTY;
    q_len = q_len - 1'b1;
    bef = prev_lnk[node];
    aft = next_lnk[node];
    put_next(bef, aft);
    put_prev(aft, bef);
    return STATUS_OK;
  endfunction

  // apply one request to the shadow state and return its response
  function automatic rsp_t apply_request(input logic [OPCODE_W-1:0] op,
                                         input logic [IDX_W-1:0] idx);
    rsp_t r;
    r = '0;
    case (op) inside
      OP_PUSH_HEAD: begin
        link_in({1'b0, idx}, NIL, head_ptr);
        on_list[idx] = 1'b1;
      end
      OP_PUSH_TAIL: begin
        link_in({1'b0, idx}, tail_ptr, NIL);
        on_list[idx] = 1'b1;
      end
      OP_UNLINK: begin
        r.status = unlink_node(idx);
        if (r.status == STATUS_OK) on_list[idx] = 1'b0;
      end
      OP_SHIFT, OP_PEEK: begin
        if (head_ptr < NIL) begin
          r.head_node = head_ptr[IDX_W-1:0];
          r.found     = 1'b1;
          if (op == OP_SHIFT) begin
            r.status = unlink_node(r.head_node);
            if (r.status == STATUS_OK) on_list[r.head_node] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.length = q_len;
    return r;
  endfunction

  // random node that is (or is not) queued
  function automatic logic [IDX_W-1:0] pick_node(input bit member);
    int start;
    int k;
    start = $urandom_range(0, NODES - 1);
    for (k = 0; k < NODES; k++) begin
      if (on_list[(start + k) % NODES] == member) return IDX_W'((start + k) % NODES);
    end
    return IDX_W'(start);
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    if (err_cnt < MAX_REPORTS) begin
      $display("%0t ns  %s: got %0d, expected %0d", $time, what, got_v, want_v);
    end
    err_cnt++;
  endtask

  // offer one request item, predict its response once it is taken
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input bit fixed, input rsp_t typed_rsp);
    rsp_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.node_index <= idx;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predicted = apply_request(op, idx);
    pending_rsp.push_back(fixed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding response
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // random request, mostly pushes of free nodes and removals of queued ones
  task automatic random_item();
    int                  dice;
    bit                  grow;
    logic [OPCODE_W-1:0] op;
    logic [IDX_W-1:0]    idx;
    dice = $urandom_range(0, 99);
    idx  = IDX_W'($urandom_range(0, NODES - 1));
    if (dice < 5) begin
      case ($urandom_range(0, 2))
        0:       op = OP_SPARE_5;
        1:       op = OP_SPARE_6;
        default: op = OP_SPARE_7;
      endcase
    end else if (dice < 12) begin
      op = OP_PEEK;
    end else begin
      grow = (q_len < fill_goal) ? ($urandom_range(0, 99) < 75) : ($urandom_range(0, 99) < 25);
      if (q_len == NIL) grow = 1'b0;
      if (grow) begin
        op  = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        idx = pick_node(1'b0);
      end else if ($urandom_range(0, 1)) begin
        op = OP_SHIFT;
      end else begin
        // on an empty queue any node is refused without a link read
        op = OP_UNLINK;
        if (q_len != '0) idx = pick_node(1'b1);
      end
    end
    send_item(op, idx, 1'b0, '0);
  endtask

  // response side: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // response checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      rsp_got = '{out_if.head_node, out_if.found, out_if.length, out_if.status};
      if (pending_rsp.size() == 0) begin
        flag_mismatch("response item with none expected, length", int'(rsp_got.length), 0);
      end else begin
        rsp_want = pending_rsp.pop_front();
        if (rsp_got.head_node !== rsp_want.head_node)
          flag_mismatch("head_node", int'(rsp_got.head_node), int'(rsp_want.head_node));
        if (rsp_got.found !== rsp_want.found)
          flag_mismatch("found", int'(rsp_got.found), int'(rsp_want.found));
        if (rsp_got.length !== rsp_want.length)
          flag_mismatch("length", int'(rsp_got.length), int'(rsp_want.length));
        if (rsp_got.status !== rsp_want.status)
          flag_mismatch("status", int'(rsp_got.status), int'(rsp_want.status));
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = '0;
    in_if.node_index = '0;
    src_idle_pct     = 35;
    snk_stall_pct    = 84;
    hold_rsp         = 1'b0;
    err_cnt          = 0;
    quiet_cycles     = 0;
    fill_goal        = 8;
    head_ptr         = NIL;
    tail_ptr         = NIL;
    q_len            = '0;
    foreach (on_list[n]) on_list[n] = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].fixed,
                '{dir_tab[i].w_head, dir_tab[i].w_found, dir_tab[i].w_len, dir_tab[i].w_status});
    end
    wait_drained();
    // the table leaves the queue empty with only stale links behind
    foreach (on_list[n]) on_list[n] = 1'b0;

    // random traffic under three idle/stall mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 35;
          snk_stall_pct = 84;
        end
        1: begin
          src_idle_pct  = 84;
          snk_stall_pct = 35;
        end
        default: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
      endcase
      for (int k = 0; k < RAND_ITEMS / 3; k++) begin
        if (k % GOAL_PERIOD == 0) begin
          case ($urandom_range(0, 3))
            0:       fill_goal = 0;
            1:       fill_goal = $urandom_range(1, 8);
            2:       fill_goal = $urandom_range(9, 64);
            default: fill_goal = $urandom_range(65, NODES);
          endcase
        end
        random_item();
      end
    end

    // fill the whole pool with responses first held off, then push past full
    wait_drained();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_rsp      = 1'b1;
    for (int n = 0; n < NODES; n++) begin
      if (!on_list[n]) send_item(OP_PUSH_TAIL, n[IDX_W-1:0], 1'b0, '0);
    end
    send_item(OP_PUSH_HEAD, tail_ptr[IDX_W-1:0], 1'b0, '0);
    send_item(OP_PUSH_TAIL, head_ptr[IDX_W-1:0], 1'b0, '0);
    repeat (24) send_item(OP_SHIFT, '0, 1'b0, '0);
    send_item(OP_PEEK, '0, 1'b0, '0);

    // drain and let any stray response show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : linked_list_queue_manager_tb

/* filelist.f */
hw/rtl/llq_pkg.sv
hw/rtl/llq_if.sv
hw/rtl/llq_ctrl.sv
hw/rtl/llq_dp.sv
hw/rtl/linked_list_queue_manager.sv
tb/sv/linked_list_queue_manager_tb.sv
